[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define DGO_ASSERT(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error("assertion failed");
`define DGO_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error("assertion failed");
`else
`define DGO_ASSERT(lbl, clk, rstn, expr)
`define DGO_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[rtl/dgo_pkg.sv]
// ---------------------------------------------------------------------------
// Degeneracy ordering package
// Field widths, operation and record codes shared by the ordering core.
// ---------------------------------------------------------------------------
package dgo_pkg;
	localparam int DEG_W = 11;
	localparam int ID_W = 10;
	localparam logic [DEG_W-1:0] DEG_LIMIT = 11'd2047;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_FETCH = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] KIND_VERTEX  = 2'd0;
	localparam logic [1:0] KIND_LATER   = 2'd1;
	localparam logic [1:0] KIND_EARLIER = 2'd2;
	localparam logic [1:0] KIND_NONE    = 2'd3;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'b0001,
		PH_SELECT    = 4'b0010,
		PH_NEIGHBORS = 4'b0100,
		PH_DONE      = 4'b1000
	} phase_t;
endpackage

[rtl/degeneracy_ordering_core.sv]
// ---------------------------------------------------------------------------
// Degeneracy ordering core
// Loads adjacency entries and peels vertices through per-degree LIFO buckets.
// ---------------------------------------------------------------------------
// A load reads, then writes the degree. A neighbor record reads its list entry,
// then its state; a later neighbor is then pushed to its new bucket. A vertex
// record scans the buckets from degree 0, then marks the vertex removed. The
// first fetch also builds the buckets: it empties each bucket head, then pushes
// each vertex. Reset and clear run a pass that zeroes the degree memory; no item
// is taken during it, configuration writes always are.
module degeneracy_ordering_core
	import dgo_pkg::*;
#(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_ENTRIES  = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] vertex_count,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [9:0]  vertex_id,
	input  logic [9:0]  neighbor_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [9:0]  node,
	output logic [9:0]  order_number,
	output logic [9:0]  degeneracy,
	output logic        last,
	output logic        overflow
);
`include "assert_macros.svh"

	// Vertex index, link (with the no-link code), count and entry widths.
	localparam int VAW = $clog2(MAX_VERTICES);
	localparam int LW  = $clog2(MAX_VERTICES + 1);
	localparam int VCW = $clog2(MAX_VERTICES + 1);
	localparam int EAW = $clog2(MAX_ENTRIES);
	localparam int ECW = $clog2(MAX_ENTRIES + 1);
	localparam logic [LW-1:0] NO_LINK = LW'(MAX_VERTICES);
	localparam logic [VAW-1:0] LAST_V = VAW'(MAX_VERTICES - 1);

	// Sequencer states, one-hot.
	typedef enum logic [17:0] {
		S_CLEAR    = 18'b000000000000000001,
		S_IDLE     = 18'b000000000000000010,
		S_LD_RD    = 18'b000000000000000100,
		S_LD_WR    = 18'b000000000000001000,
		S_BCLR     = 18'b000000000000010000,
		S_BLD_RD   = 18'b000000000000100000,
		S_BLD_DEG  = 18'b000000000001000000,
		S_PUSH_RD  = 18'b000000000010000000,
		S_PUSH_WR  = 18'b000000000100000000,
		S_PUSH_LNK = 18'b000000001000000000,
		S_SC_RD    = 18'b000000010000000000,
		S_SC_CK    = 18'b000000100000000000,
		S_RM_RD    = 18'b000001000000000000,
		S_RM_WR    = 18'b000010000000000000,
		S_NB_RD    = 18'b000100000000000000,
		S_NB_U     = 18'b001000000000000000,
		S_NB_UL    = 18'b010000000000000000,
		S_EMIT     = 18'b100000000000000000
	} state_t;

	state_t              state_q;
	phase_t              phase_q;
	logic [10:0]         vcount_q;
	logic [ECW-1:0]      ec_q;
	logic                ovf_q;
	logic [VCW-1:0]      active_q;
	logic [VCW-1:0]      rmc_q;
	logic [VAW-1:0]      rdeg_q;
	logic [VAW-1:0]      cnt_q;
	logic [VCW-1:0]      bi_q;
	logic [ID_W-1:0]     ld_vid_q;
	logic [ID_W-1:0]     ld_nid_q;
	logic [VAW-1:0]      push_v_q;
	logic [DEG_W-1:0]    push_deg_q;
	logic [LW-1:0]       h_q;
	logic [EAW-1:0]      cur_first_q;
	logic [DEG_W-1:0]    nb_idx_q;
	logic [DEG_W-1:0]    nb_cnt_q;
	logic [VCW-1:0]      cur_order_q;
	logic [ID_W-1:0]     u_q;
	logic [1:0]          st_kind_q;
	logic [ID_W-1:0]     st_node_q;
	logic [ID_W-1:0]     st_order_q;
	logic                st_last_q;
	logic                out_valid_q;
	logic [1:0]          out_kind_q;
	logic [ID_W-1:0]     out_node_q;
	logic [ID_W-1:0]     out_order_q;
	logic [ID_W-1:0]     out_deg_q;
	logic                out_last_q;
	logic                out_ovf_q;

	// Memory ports.
	logic            adj_we, fe_we, id_we, rd_we, rm_we, bh_we, ln_we, lp_we;
	logic [EAW-1:0]  adj_wa, adj_ra, fe_wd;
	logic [VAW-1:0]  fe_wa, fe_ra, id_wa, id_ra, rd_wa, rd_ra, rm_wa, rm_ra;
	logic [VAW-1:0]  bh_wa, bh_ra, ln_wa, ln_ra, lp_wa, lp_ra;
	logic [ID_W-1:0] adj_wd, adj_rd;
	logic [EAW-1:0]  fe_rd;
	logic [DEG_W-1:0] id_wd, id_rd, rd_wd, rd_rd;
	logic            rm_wd, rm_rd;
	logic [LW-1:0]   bh_wd, bh_rd, ln_wd, ln_rd, lp_wd, lp_rd;

	logic in_fire, out_slot, present, unlink, nb_end;
	logic [DEG_W-1:0] nb_next;

	function automatic logic [VAW-1:0] bucket_of(input logic [DEG_W-1:0] deg);
		if (32'(deg) >= MAX_VERTICES) begin
			return LAST_V;
		end
		return VAW'(deg);
	endfunction

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_slot  = !out_valid_q || out_ready;

	// A neighbor is still present if it lies in the graph and is not removed.
	assign present = (32'(u_q) < 32'(active_q)) && !rm_rd;
	assign unlink  = (state_q == S_RM_WR) || ((state_q == S_NB_UL) && present);
	assign nb_next = nb_idx_q + 1'b1;
	assign nb_end  = (nb_next >= nb_cnt_q);

	// Memory address and write control, decoded from the sequencer state.
	always_comb begin
		adj_we = 1'b0; adj_wa = EAW'(ec_q); adj_wd = ld_nid_q;
		adj_ra = EAW'(32'(cur_first_q) + 32'(nb_idx_q));
		fe_we = 1'b0;  fe_wa = VAW'(ld_vid_q); fe_wd = EAW'(ec_q); fe_ra = push_v_q;
		id_we = 1'b0;  id_wa = cnt_q; id_wd = '0; id_ra = push_v_q;
		rd_we = 1'b0;  rd_wa = push_v_q; rd_wd = push_deg_q; rd_ra = push_v_q;
		rm_we = 1'b0;  rm_wa = push_v_q; rm_wd = 1'b0; rm_ra = VAW'(adj_rd);
		bh_we = 1'b0;  bh_wa = cnt_q; bh_wd = NO_LINK; bh_ra = cnt_q;
		ln_we = 1'b0;  ln_wa = push_v_q; ln_wd = bh_rd; ln_ra = push_v_q;
		lp_we = 1'b0;  lp_wa = push_v_q; lp_wd = NO_LINK; lp_ra = push_v_q;
		case (state_q)
			S_CLEAR: begin
				id_we = 1'b1;
			end
			S_LD_RD: begin
				id_ra = VAW'(ld_vid_q);
			end
			S_LD_WR: begin
				if (id_rd < DEG_LIMIT) begin
					id_we  = 1'b1;
					id_wa  = VAW'(ld_vid_q);
					id_wd  = id_rd + 1'b1;
					fe_we  = (id_rd == '0);
					adj_we = 1'b1;
				end
			end
			S_BCLR: begin
				bh_we = 1'b1;
			end
			S_BLD_RD: begin
				id_ra = VAW'(bi_q);
			end
			S_BLD_DEG: begin
				rm_we = 1'b1;
				rm_wa = VAW'(bi_q);
			end
			S_PUSH_RD: begin
				bh_ra = bucket_of(push_deg_q);
			end
			S_PUSH_WR: begin
				lp_we = 1'b1;
				ln_we = 1'b1;
				rd_we = 1'b1;
				bh_we = 1'b1;
				bh_wa = bucket_of(push_deg_q);
				bh_wd = LW'(push_v_q);
			end
			S_PUSH_LNK: begin
				lp_we = (h_q < NO_LINK);
				lp_wa = VAW'(h_q);
				lp_wd = LW'(push_v_q);
			end
			S_RM_RD: begin
				rm_we = 1'b1;
				rm_wd = 1'b1;
			end
			S_NB_U: begin
				rd_ra = VAW'(adj_rd);
				ln_ra = VAW'(adj_rd);
				lp_ra = VAW'(adj_rd);
			end
			default: begin
			end
		endcase
		// Unlink from the bucket list: predecessor or bucket head, then successor.
		if (unlink) begin
			if (lp_rd < NO_LINK) begin
				ln_we = 1'b1;
				ln_wa = VAW'(lp_rd);
				ln_wd = ln_rd;
			end else begin
				bh_we = 1'b1;
				bh_wa = bucket_of(rd_rd);
				bh_wd = ln_rd;
			end
			lp_we = (ln_rd < NO_LINK);
			lp_wa = VAW'(ln_rd);
			lp_wd = lp_rd;
		end
	end

	dgo_ram #(.WIDTH(ID_W), .DEPTH(MAX_ENTRIES)) u_adj (
		.clk(clk), .we(adj_we), .waddr(adj_wa), .wdata(adj_wd), .raddr(adj_ra), .rdata(adj_rd)
	);
	dgo_ram #(.WIDTH(EAW), .DEPTH(MAX_VERTICES)) u_first (
		.clk(clk), .we(fe_we), .waddr(fe_wa), .wdata(fe_wd), .raddr(fe_ra), .rdata(fe_rd)
	);
	dgo_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_ideg (
		.clk(clk), .we(id_we), .waddr(id_wa), .wdata(id_wd), .raddr(id_ra), .rdata(id_rd)
	);
	dgo_ram #(.WIDTH(DEG_W), .DEPTH(MAX_VERTICES)) u_rdeg (
		.clk(clk), .we(rd_we), .waddr(rd_wa), .wdata(rd_wd), .raddr(rd_ra), .rdata(rd_rd)
	);
	dgo_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_rmark (
		.clk(clk), .we(rm_we), .waddr(rm_wa), .wdata(rm_wd), .raddr(rm_ra), .rdata(rm_rd)
	);
	dgo_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_head (
		.clk(clk), .we(bh_we), .waddr(bh_wa), .wdata(bh_wd), .raddr(bh_ra), .rdata(bh_rd)
	);
	dgo_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_next (
		.clk(clk), .we(ln_we), .waddr(ln_wa), .wdata(ln_wd), .raddr(ln_ra), .rdata(ln_rd)
	);
	dgo_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_prev (
		.clk(clk), .we(lp_we), .waddr(lp_wa), .wdata(lp_wd), .raddr(lp_ra), .rdata(lp_rd)
	);

	// Sequencer. Every record is staged, then handed to the output register in
	// S_EMIT, which parts the result side from the input side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			phase_q     <= PH_IDLE;
			vcount_q    <= '0;
			ec_q        <= '0;
			ovf_q       <= 1'b0;
			active_q    <= '0;
			rmc_q       <= '0;
			rdeg_q      <= '0;
			cnt_q       <= '0;
			bi_q        <= '0;
			ld_vid_q    <= '0;
			ld_nid_q    <= '0;
			push_v_q    <= '0;
			push_deg_q  <= '0;
			h_q         <= '0;
			cur_first_q <= '0;
			nb_idx_q    <= '0;
			nb_cnt_q    <= '0;
			cur_order_q <= '0;
			u_q         <= '0;
			st_kind_q   <= KIND_NONE;
			st_node_q   <= '0;
			st_order_q  <= '0;
			st_last_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_NONE;
			out_node_q  <= '0;
			out_order_q <= '0;
			out_deg_q   <= '0;
			out_last_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				vcount_q <= vertex_count;
			end
			// In S_EMIT the slot is refilled below instead.
			if (out_valid_q && out_ready && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_V) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_fire) begin
						ld_vid_q <= vertex_id;
						ld_nid_q <= neighbor_id;
						case (op)
							OP_LOAD: begin
								if (phase_q == PH_IDLE) begin
									if (32'(ec_q) >= MAX_ENTRIES ||
										32'(vertex_id) >= MAX_VERTICES) begin
										ovf_q <= 1'b1;
									end else begin
										state_q <= S_LD_RD;
									end
								end
							end
							OP_CLEAR: begin
								ec_q     <= '0;
								rmc_q    <= '0;
								rdeg_q   <= '0;
								ovf_q    <= 1'b0;
								active_q <= '0;
								nb_idx_q <= '0;
								nb_cnt_q <= '0;
								phase_q  <= PH_IDLE;
								cnt_q    <= '0;
								state_q  <= S_CLEAR;
							end
							OP_FETCH: begin
								case (phase_q)
									PH_IDLE: begin
										active_q <= (32'(vcount_q) > MAX_VERTICES) ?
											VCW'(MAX_VERTICES) : VCW'(vcount_q);
										rmc_q   <= '0;
										cnt_q   <= '0;
										bi_q    <= '0;
										state_q <= S_BCLR;
									end
									PH_NEIGHBORS: begin
										state_q <= S_NB_RD;
									end
									PH_SELECT: begin
										if (rmc_q < active_q) begin
											cnt_q   <= '0;
											state_q <= S_SC_RD;
										end else begin
											phase_q    <= PH_DONE;
											st_kind_q  <= KIND_NONE;
											st_node_q  <= '0;
											st_order_q <= '0;
											st_last_q  <= 1'b0;
											state_q    <= S_EMIT;
										end
									end
									default: begin
										st_kind_q  <= KIND_NONE;
										st_node_q  <= '0;
										st_order_q <= '0;
										st_last_q  <= 1'b0;
										state_q    <= S_EMIT;
									end
								endcase
							end
							default: begin
							end
						endcase
					end
				end
				S_LD_RD: begin
					state_q <= S_LD_WR;
				end
				S_LD_WR: begin
					if (id_rd >= DEG_LIMIT) begin
						ovf_q <= 1'b1;
					end else begin
						ec_q <= ec_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_BCLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_V) begin
						state_q <= S_BLD_RD;
					end
				end
				S_BLD_RD: begin
					if (bi_q == active_q) begin
						if (active_q != '0) begin
							phase_q <= PH_SELECT;
							cnt_q   <= '0;
							state_q <= S_SC_RD;
						end else begin
							phase_q    <= PH_DONE;
							st_kind_q  <= KIND_NONE;
							st_node_q  <= '0;
							st_order_q <= '0;
							st_last_q  <= 1'b0;
							state_q    <= S_EMIT;
						end
					end else begin
						state_q <= S_BLD_DEG;
					end
				end
				S_BLD_DEG: begin
					push_v_q   <= VAW'(bi_q);
					push_deg_q <= id_rd;
					state_q    <= S_PUSH_RD;
				end
				S_PUSH_RD: begin
					// A degree past the last bucket is parked there and flagged.
					if (32'(push_deg_q) >= MAX_VERTICES) begin
						ovf_q <= 1'b1;
					end
					state_q <= S_PUSH_WR;
				end
				S_PUSH_WR: begin
					h_q     <= bh_rd;
					state_q <= S_PUSH_LNK;
				end
				S_PUSH_LNK: begin
					if (phase_q == PH_IDLE) begin
						bi_q    <= bi_q + 1'b1;
						state_q <= S_BLD_RD;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_SC_RD: begin
					state_q <= S_SC_CK;
				end
				S_SC_CK: begin
					if (bh_rd < NO_LINK) begin
						if (cnt_q > rdeg_q) begin
							rdeg_q <= cnt_q;
						end
						push_v_q <= VAW'(bh_rd);
						state_q  <= S_RM_RD;
					end else if (cnt_q == LAST_V) begin
						phase_q    <= PH_DONE;
						st_kind_q  <= KIND_NONE;
						st_node_q  <= '0;
						st_order_q <= '0;
						st_last_q  <= 1'b0;
						state_q    <= S_EMIT;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_SC_RD;
					end
				end
				S_RM_RD: begin
					state_q <= S_RM_WR;
				end
				S_RM_WR: begin
					cur_order_q <= rmc_q;
					rmc_q       <= rmc_q + 1'b1;
					nb_cnt_q    <= id_rd;
					nb_idx_q    <= '0;
					cur_first_q <= fe_rd;
					phase_q     <= (id_rd != '0) ? PH_NEIGHBORS : PH_SELECT;
					st_kind_q   <= KIND_VERTEX;
					st_node_q   <= ID_W'(push_v_q);
					st_order_q  <= ID_W'(rmc_q);
					st_last_q   <= (id_rd == '0) && (32'(rmc_q) + 1 >= 32'(active_q));
					state_q     <= S_EMIT;
				end
				S_NB_RD: begin
					state_q <= S_NB_U;
				end
				S_NB_U: begin
					u_q     <= adj_rd;
					state_q <= S_NB_UL;
				end
				S_NB_UL: begin
					nb_idx_q   <= nb_next;
					if (nb_end) begin
						phase_q <= PH_SELECT;
					end
					st_node_q  <= u_q;
					st_order_q <= ID_W'(cur_order_q);
					st_last_q  <= nb_end && (rmc_q >= active_q);
					if (present) begin
						// Decrement saturates at zero and flags the underflow.
						if (rd_rd == '0) begin
							ovf_q <= 1'b1;
						end
						push_deg_q <= (rd_rd == '0) ? rd_rd : rd_rd - 1'b1;
						push_v_q   <= VAW'(u_q);
						st_kind_q  <= KIND_LATER;
						state_q    <= S_PUSH_RD;
					end else begin
						st_kind_q <= KIND_EARLIER;
						state_q   <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_slot) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= st_kind_q;
						out_node_q  <= st_node_q;
						out_order_q <= st_order_q;
						out_deg_q   <= ID_W'(rdeg_q);
						out_last_q  <= st_last_q;
						out_ovf_q   <= ovf_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = out_kind_q;
	assign node         = out_node_q;
	assign order_number = out_order_q;
	assign degeneracy   = out_deg_q;
	assign last         = out_last_q;
	assign overflow     = out_ovf_q;

	// A staged record moves to the output register as soon as the slot is free.
	`DGO_ASSERT_NEXT(a_emit_loads, clk, arst_n, (state_q == S_EMIT) && out_slot, out_valid_q)
	// The ordering never removes more vertices than the graph holds.
	`DGO_ASSERT(a_removed_bound, clk, arst_n, rmc_q <= active_q)
	// While neighbors are pending, the neighbor cursor stays inside the list.
	`DGO_ASSERT(a_nb_range, clk, arst_n, (phase_q != PH_NEIGHBORS) || (nb_idx_q < nb_cnt_q))
endmodule

[rtl/dgo_ram.sv]
// ---------------------------------------------------------------------------
// Simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module dgo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[sim/dgo_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Degeneracy ordering checker
// Watches the configuration, item and record channels, predicts every record
// the ordering core owes and compares each delivered record with it.
// ---------------------------------------------------------------------------
module dgo_checker
	import dgo_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [10:0] vertex_count,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  op,
	input  logic [9:0]  vertex_id,
	input  logic [9:0]  neighbor_id,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  kind,
	input  logic [9:0]  node,
	input  logic [9:0]  order_number,
	input  logic [9:0]  degeneracy,
	input  logic        last,
	input  logic        overflow,
	output int          errors,
	output int          pending
);
	localparam int NV = 1024;
	localparam int NE = 8192;
	localparam logic [10:0] NO_LINK = 11'd1024;

	typedef struct packed {
		logic [1:0] kind;
		logic [9:0] node;
		logic [9:0] order_number;
		logic [9:0] degeneracy;
		logic       last;
		logic       overflow;
	} dgo_rec_t;

	dgo_rec_t expected_records[$];
	int       err_count;

	// Mirror of the graph store and the bucket queue.
	logic [9:0]  adj_store [NE];
	logic [12:0] first_ent [NV];
	logic [10:0] init_deg  [NV];
	logic [10:0] rem_deg   [NV];
	logic        gone      [NV];
	logic [10:0] head      [NV];
	logic [10:0] nxt       [NV];
	logic [10:0] prv       [NV];
	logic [13:0] n_entries;
	logic [10:0] n_removed;
	logic [9:0]  degen;
	logic [10:0] count_reg;
	logic        ovf;
	phase_t      phase;
	logic [10:0] n_active;
	logic [9:0]  cur_v;
	logic [9:0]  cur_order;
	logic [10:0] nb_idx;
	logic [10:0] nb_cnt;

	function automatic int bucket_for(logic [10:0] d);
		return (d >= NV) ? NV - 1 : int'(d);
	endfunction

	function automatic void bucket_insert(int v);
		int b;
		b = bucket_for(rem_deg[v]);
		if (b != int'(rem_deg[v]))
			ovf = 1'b1;
		prv[v] = NO_LINK;
		nxt[v] = head[b];
		if (head[b] < NO_LINK)
			prv[head[b]] = 11'(v);
		head[b] = 11'(v);
	endfunction

	function automatic void bucket_remove(int v);
		logic [10:0] p;
		logic [10:0] n;
		p = prv[v];
		n = nxt[v];
		if (p < NO_LINK)
			nxt[p] = n;
		else
			head[bucket_for(rem_deg[v])] = n;
		if (n < NO_LINK)
			prv[n] = p;
	endfunction

	function automatic void wipe_graph();
		for (int i = 0; i < NV; i++) begin
			init_deg[i] = '0;
			gone[i] = 1'b0;
			head[i] = NO_LINK;
		end
		n_entries = '0;
		n_removed = '0;
		degen = '0;
		ovf = 1'b0;
		phase = PH_IDLE;
		n_active = '0;
		nb_idx = '0;
		nb_cnt = '0;
	endfunction

	function automatic void take_entry(logic [9:0] v, logic [9:0] nb);
		if (phase != PH_IDLE)
			return;
		if (n_entries >= NE || init_deg[v] >= DEG_LIMIT) begin
			ovf = 1'b1;
			return;
		end
		if (init_deg[v] == 0)
			first_ent[v] = 13'(n_entries);
		adj_store[n_entries] = nb;
		n_entries++;
		init_deg[v]++;
	endfunction

	function automatic dgo_rec_t next_record();
		dgo_rec_t r;
		int idx;
		int u;
		r = '0;
		if (phase == PH_IDLE) begin
			n_active = (count_reg > NV) ? 11'(NV) : count_reg;
			for (int i = 0; i < NV; i++)
				head[i] = NO_LINK;
			for (int i = 0; i < n_active; i++) begin
				rem_deg[i] = init_deg[i];
				gone[i] = 1'b0;
				bucket_insert(i);
			end
			n_removed = '0;
			phase = PH_SELECT;
		end
		if (phase == PH_NEIGHBORS) begin
			idx = int'(first_ent[cur_v]) + int'(nb_idx);
			u = (idx < NE) ? int'(adj_store[idx]) : 0;
			r.kind = KIND_EARLIER;
			if (u < n_active && !gone[u]) begin
				r.kind = KIND_LATER;
				bucket_remove(u);
				if (rem_deg[u] == 0)
					ovf = 1'b1;
				else
					rem_deg[u]--;
				bucket_insert(u);
			end
			nb_idx++;
			if (nb_idx >= nb_cnt)
				phase = PH_SELECT;
			r.node = 10'(u);
			r.order_number = cur_order;
			r.degeneracy = degen;
			r.last = (phase == PH_SELECT) && (n_removed >= n_active);
			r.overflow = ovf;
			return r;
		end
		if (phase == PH_SELECT && n_removed < n_active) begin
			for (int d = 0; d < NV; d++) begin
				if (head[d] < NO_LINK) begin
					u = int'(head[d]);
					if (d > degen)
						degen = 10'(d);
					bucket_remove(u);
					gone[u] = 1'b1;
					cur_v = 10'(u);
					cur_order = 10'(n_removed);
					n_removed++;
					nb_idx = '0;
					nb_cnt = init_deg[u];
					phase = (nb_cnt > 0) ? PH_NEIGHBORS : PH_SELECT;
					r.kind = KIND_VERTEX;
					r.node = 10'(u);
					r.order_number = cur_order;
					r.degeneracy = degen;
					r.last = (nb_cnt == 0) && (n_removed >= n_active);
					r.overflow = ovf;
					return r;
				end
			end
		end
		phase = PH_DONE;
		r.kind = KIND_NONE;
		r.degeneracy = degen;
		r.overflow = ovf;
		return r;
	endfunction

	task automatic report(string what, int got, int want);
		$display("%0t: record %s mismatch, got %0d expected %0d", $realtime, what, got, want);
		err_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		dgo_rec_t want;
		if (!arst_n) begin
			wipe_graph();
			count_reg = '0;
			expected_records.delete();
			err_count = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				count_reg = vertex_count;
			if (in_valid && in_ready) begin
				case (op)
					OP_LOAD:  take_entry(vertex_id, neighbor_id);
					OP_FETCH: expected_records.push_back(next_record());
					OP_CLEAR: wipe_graph();
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_records.size() == 0) begin
					$display("%0t: record delivered with none outstanding", $realtime);
					err_count++;
				end else begin
					want = expected_records.pop_front();
					if (kind != want.kind)
						report("kind", kind, want.kind);
					if (node != want.node)
						report("node", node, want.node);
					if (order_number != want.order_number)
						report("order_number", order_number, want.order_number);
					if (degeneracy != want.degeneracy)
						report("degeneracy", degeneracy, want.degeneracy);
					if (last != want.last)
						report("last", last, want.last);
					if (overflow != want.overflow)
						report("overflow", overflow, want.overflow);
				end
			end
			errors <= err_count;
			pending <= expected_records.size();
		end
	end
endmodule

[sim/tb_degeneracy_ordering_core.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Degeneracy ordering core testbench
// Loads directed corner-case graphs, a vertex whose degree passes the last
// bucket and many random small graphs, peels them record by record under
// random idling on both channels, and lets the checker compare every record.
// ---------------------------------------------------------------------------
module tb_degeneracy_ordering_core
	import dgo_pkg::*;
;
	// Far above the slowest legal run: builds of the full vertex range, a
	// clearing pass after every clear and long stalls on every record.
	localparam int CYCLE_LIMIT = 20000000;
	localparam int TOTAL_ITEMS = 1650;
	localparam int QUIET_AFTER = 1450;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [10:0] vertex_count;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [9:0]  vertex_id;
	logic [9:0]  neighbor_id;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  kind;
	logic [9:0]  node;
	logic [9:0]  order_number;
	logic [9:0]  degeneracy;
	logic        last;
	logic        overflow;
	int          errors;
	int          pending;

	int cycles;
	int items_sent;
	bit quiet;
	int hold_requests;

	degeneracy_ordering_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .vertex_count(vertex_count),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .vertex_id(vertex_id), .neighbor_id(neighbor_id),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .node(node), .order_number(order_number),
		.degeneracy(degeneracy), .last(last), .overflow(overflow)
	);

	dgo_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .vertex_count(vertex_count),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .vertex_id(vertex_id), .neighbor_id(neighbor_id),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .node(node), .order_number(order_number),
		.degeneracy(degeneracy), .last(last), .overflow(overflow),
		.errors(errors), .pending(pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// The run is cut off at the cycle limit, which only a hang can reach.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Record side. Ready drops in random bursts; a hold request from the
	// stimulus makes it refuse records for a long stretch so that the core
	// backs up and stops taking items. Near the end the side stays ready.
	always @(posedge clk) begin
		static int burst = 0;
		static int seen_holds = 0;
		if (hold_requests != seen_holds) begin
			seen_holds = hold_requests;
			burst = 400;
		end
		if (burst > 0) begin
			burst--;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 15) == 0) begin
			burst = $urandom_range(1, 12) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// One item transfer. A random idle burst may come first; the payload is
	// then held until the core takes it. Called at a rising edge and returns
	// at the edge of the transfer, so back-to-back items keep valid high.
	task automatic send_item(logic [1:0] o, logic [9:0] v, logic [9:0] nb);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		vertex_id <= v;
		neighbor_id <= nb;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// The sender pauses until every owed record has arrived. Loads and
	// clears give no record, so the core must also be back to taking items.
	task automatic drain();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		do @(posedge clk); while (pending != 0 || !in_ready);
	endtask

	// Register writes happen only with the core idle.
	task automatic write_vertex_count(logic [10:0] value);
		drain();
		cfg_valid <= 1'b1;
		vertex_count <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic fetch_records(int count);
		for (int i = 0; i < count; i++)
			send_item(OP_FETCH, '0, '0);
	endtask

	// A random graph on n vertices. Most of the time the lists are symmetric
	// and well formed; sometimes noise is mixed in: unknown ops, neighbors
	// outside the graph and entries for vertices that are not counted.
	// Returns how many records the full ordering will give.
	task automatic load_random_graph(int n, output int records);
		int lists[24][$];
		int density;
		bit noisy;
		density = $urandom_range(5, 60);
		noisy = ($urandom_range(0, 3) == 0);
		records = n;
		for (int i = 0; i < n; i++)
			for (int j = i; j < n; j++)
				if ($urandom_range(0, 99) < density) begin
					lists[i].push_back(j);
					if (j != i)
						lists[j].push_back(i);
				end
		for (int i = 0; i < n; i++) begin
			lists[i].shuffle();
			foreach (lists[i][k]) begin
				send_item(OP_LOAD, 10'(i), 10'(lists[i][k]));
				records++;
				if (noisy && $urandom_range(0, 7) == 0) begin
					send_item(OP_LOAD, 10'(i), 10'($urandom_range(0, 1023)));
					records++;
				end
				if (noisy && $urandom_range(0, 15) == 0)
					send_item(OP_UNUSED, 10'($urandom), 10'($urandom));
			end
		end
		if (noisy)
			send_item(OP_LOAD, 10'($urandom_range(n, 1023)), 10'($urandom));
	endtask

	initial begin
		int records;
		int n;
		int phase_no;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		vertex_count = '0;
		in_valid = 1'b0;
		op = OP_LOAD;
		vertex_id = '0;
		neighbor_id = '0;
		out_ready = 1'b0;
		quiet = 1'b0;
		hold_requests = 0;
		cycles = 0;
		items_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With no vertices the ordering is done at once.
		write_vertex_count(11'd0);
		fetch_records(2);

		// Three vertices whose removal order drives vertex 0 below zero;
		// vertex 0 also names a neighbor outside the graph. An entry for the
		// top vertex id is loaded but never counted. Past the end, loads are
		// ignored and an unknown op does nothing.
		write_vertex_count(11'd3);
		send_item(OP_LOAD, 10'd0, 10'd9);
		send_item(OP_LOAD, 10'd0, 10'd9);
		send_item(OP_LOAD, 10'd1, 10'd0);
		send_item(OP_LOAD, 10'd1, 10'd0);
		send_item(OP_LOAD, 10'd1, 10'd0);
		send_item(OP_LOAD, 10'd2, 10'd1);
		send_item(OP_LOAD, 10'd2, 10'd1);
		send_item(OP_LOAD, 10'd1023, 10'd1023);
		fetch_records(11);
		send_item(OP_LOAD, 10'd0, 10'd1);
		send_item(OP_UNUSED, 10'd1023, 10'd1023);
		fetch_records(1);
		send_item(OP_CLEAR, '0, '0);

		// Vertex 0 gets a degree past the vertex range and lands in the last
		// bucket. A count above the vertex range is clamped to it.
		write_vertex_count(11'd2047);
		for (int i = 0; i < 1030; i++)
			send_item(OP_LOAD, 10'd0, 10'($urandom_range(0, 1023)));
		fetch_records(40);
		send_item(OP_CLEAR, '0, '0);

		// Random graphs, each under its own vertex count.
		phase_no = 0;
		while (items_sent < TOTAL_ITEMS) begin
			phase_no++;
			quiet = (items_sent > QUIET_AFTER);
			if (phase_no % 15 == 7) begin
				// The whole vertex range with only a few edges; peel a part.
				write_vertex_count(11'd1024);
				load_random_graph(4, records);
				fetch_records(30);
			end else begin
				n = $urandom_range(1, 24);
				write_vertex_count(11'(n));
				load_random_graph(n, records);
				if (phase_no == 3) begin
					// Refuse records for a long time while fetches keep coming.
					hold_requests++;
					fetch_records(records + 1);
				end else if ($urandom_range(0, 4) == 0) begin
					fetch_records($urandom_range(1, records));
				end else begin
					fetch_records(records + $urandom_range(0, 2));
					if ($urandom_range(0, 3) == 0)
						send_item(OP_LOAD, 10'($urandom), 10'($urandom));
				end
				if ($urandom_range(0, 5) == 0)
					drain();
			end
			send_item(OP_CLEAR, '0, '0);
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
